/* rtl/core/rgb_to_hsv_converter_assert.svh */
// assertion macros shared by the rgb_to_hsv_converter rtl
// every user module has clk and rst (synchronous, active high) in scope
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RHC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RHC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rhc_pkg.sv */
// shared types, constants and helpers of the rgb to hsv converter
// no dependencies
`default_nettype none

package rhc_pkg;

  localparam int CHAN_W        = 8;
  localparam int HUE_W         = 15;
  localparam int SAT_W         = 16;
  localparam int VAL_W         = 15;
  localparam int HUE_FRAC_BITS = 6;

  // divider geometry: quotient bits, denominator 2*channel, numerator
  localparam int QUO_W = (9 + HUE_FRAC_BITS > SAT_W) ? 9 + HUE_FRAC_BITS : SAT_W;
  localparam int DEN_W = CHAN_W + 1;
  localparam int NUM_W = QUO_W + DEN_W;

  // hue offset in units of 60/delta degrees before scaling: 0 .. 6*255-1
  localparam int HM_W         = 11;
  localparam int HUE_DEG_STEP = 60;
  localparam logic [QUO_W-1:0] HUE_TOP = QUO_W'(360 * (2 ** HUE_FRAC_BITS) - 1);

  // saturation numerator is delta * 2^16 (twice Q1.15 one)
  localparam int SAT_SHIFT = SAT_W;
  localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(32768);

  // value = floor((cmax*25600 + 127) / 255) via reciprocal 2^31/255 rounded up
  localparam int VAL_Y_W     = 23;
  localparam int VAL_SCALE   = 25600;
  localparam int VAL_HALF    = 127;
  localparam int VAL_RECIP_W = 24;
  localparam logic [VAL_RECIP_W-1:0] VAL_RECIP = VAL_RECIP_W'(8421505);
  localparam int VAL_SHIFT   = 31;
  localparam int VAL_PROD_W  = VAL_Y_W + VAL_RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CNT_W = QUEUE_AW + 1;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } rhc_sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rhc_pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [VAL_W-1:0] brightness;
  } rhc_hsv_t;

  // classified pixel waiting for the dividers
  typedef struct packed {
    logic [NUM_W-1:0] hue_x;
    logic [DEN_W-1:0] hue_d;
    logic [NUM_W-1:0] sat_x;
    logic [DEN_W-1:0] sat_d;
    logic             gray;
    logic [VAL_W-1:0] val;
  } rhc_job_t;

  // one restoring divider lane: partial remainder, shifting word, divisor
  typedef struct packed {
    logic [DEN_W-1:0] p;
    logic [QUO_W-1:0] w;
    logic [DEN_W-1:0] d;
  } rhc_lane_t;

  typedef struct packed {
    rhc_lane_t        hue;
    rhc_lane_t        sat;
    logic             gray;
    logic [VAL_W-1:0] val;
  } rhc_div_t;

endpackage

`default_nettype wire

/* rtl/core/rhc_front.sv */
// front end: max/min search, sector pick, numerator and divisor setup
// depends on rhc_pkg
`default_nettype none
`include "rgb_to_hsv_converter_assert.svh"

module rhc_front
  import rhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rhc_pixel_t pixel,
  input  wire logic       push,
  output logic            full,
  output rhc_job_t        job,
  output logic            job_valid,
  input  wire logic       job_full
);

  logic [CHAN_W-1:0]  r, g, b, cmax, cmin, delta;
  rhc_sector_t        sector;
  logic signed [11:0] diff, kd, m, six_d;
  logic [HM_W-1:0]    hm;
  logic [VAL_Y_W-1:0] val_y;

  logic               a_valid;
  logic [CHAN_W-1:0]  a_cmax, a_delta;
  logic [HM_W-1:0]    a_hm;
  logic [VAL_Y_W-1:0] a_val_y;

  logic [NUM_W-1:0]      hue_n;
  logic [VAL_PROD_W-1:0] val_prod;

  always_comb begin
    r = pixel.red;
    g = pixel.green;
    b = pixel.blue;
    cmax = r;
    cmin = r;
    if (g > cmax) cmax = g;
    if (b > cmax) cmax = b;
    if (g < cmin) cmin = g;
    if (b < cmin) cmin = b;
    delta = cmax - cmin;
  end

  // ties go to red, then green
  always_comb begin
    priority if (cmax == r) begin
      sector = SECT_RED;
    end else if (cmax == g) begin
      sector = SECT_GREEN;
    end else begin
      sector = SECT_BLUE;
    end
  end

  always_comb begin
    unique case (sector)
      SECT_RED: begin
        diff = $signed({4'b0, g}) - $signed({4'b0, b});
        kd   = 12'sd0;
      end
      SECT_GREEN: begin
        diff = $signed({4'b0, b}) - $signed({4'b0, r});
        kd   = $signed({3'b0, delta, 1'b0});
      end
      SECT_BLUE: begin
        diff = $signed({4'b0, r}) - $signed({4'b0, g});
        kd   = $signed({2'b0, delta, 2'b0});
      end
      default: begin
        diff = 12'sd0;
        kd   = 12'sd0;
      end
    endcase
    six_d = $signed(12'({delta, 2'b00}) + 12'({delta, 1'b0}));
    m = diff + kd;
    if (m < 12'sd0) m = m + six_d;
    hm = m[HM_W-1:0];
    val_y = VAL_Y_W'(cmax) * VAL_Y_W'(VAL_SCALE) + VAL_Y_W'(VAL_HALF);
  end

  assign full = a_valid && job_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!full) begin
      a_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      a_cmax  <= cmax;
      a_delta <= delta;
      a_hm    <= hm;
      a_val_y <= val_y;
    end
  end

  // numerators carry the 2x of round-to-nearest; divisors are 2*delta, 2*cmax
  always_comb begin
    hue_n     = NUM_W'(a_hm) * NUM_W'(HUE_DEG_STEP);
    job.hue_x = (hue_n << (HUE_FRAC_BITS + 1)) + NUM_W'(a_delta);
    job.hue_d = {a_delta, 1'b0};
    job.sat_x = (NUM_W'(a_delta) << SAT_SHIFT) + NUM_W'(a_cmax);
    job.sat_d = {a_cmax, 1'b0};
    job.gray  = (a_delta == '0);
    val_prod  = VAL_PROD_W'(a_val_y) * VAL_PROD_W'(VAL_RECIP);
    job.val   = val_prod[VAL_SHIFT +: VAL_W];
  end

  assign job_valid = a_valid;

  `RHC_ASSERT_NEXT(front_hold_a, a_valid && job_full, a_valid && $stable(a_cmax) && $stable(a_hm), "front item changed while queue full")
  `RHC_ASSERT_IMPL(front_gray_sector, a_valid && a_delta == '0, a_hm == '0, "gray pixel with nonzero hue offset")

endmodule

`default_nettype wire

/* rtl/core/rhc_queue.sv */
// short job queue between front end and divider pipeline
// depends on rhc_pkg
`default_nettype none
`include "rgb_to_hsv_converter_assert.svh"

module rhc_queue
  import rhc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire rhc_job_t wr_data,
  input  wire logic     wr_valid,
  output logic          full,
  output rhc_job_t      rd_data,
  output logic          empty,
  input  wire logic     rd_take
);

  rhc_job_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wptr, rptr;
  logic [QUEUE_CNT_W-1:0] count, count_next;
  logic                   wr_en, rd_en;

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign wr_en   = wr_valid && !full;
  assign rd_en   = rd_take && !empty;
  assign rd_data = slots[rptr];

  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) count_next = count + 1'b1;
    if (rd_en && !wr_en) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= wptr + 1'b1;
      if (rd_en) rptr <= rptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wptr] <= wr_data;
  end

  `RHC_ASSERT_IMPL(queue_count_bound, 1'b1, count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `RHC_ASSERT_IMPL(queue_ptr_gap, 1'b1, QUEUE_AW'(wptr - rptr) == count[QUEUE_AW-1:0], "queue pointers disagree with count")

endmodule

`default_nettype wire

/* rtl/core/rhc_back.sv */
// back end: two restoring divider lanes, one quotient bit per stage, plus output register
// depends on rhc_pkg
`default_nettype none
`include "rgb_to_hsv_converter_assert.svh"

module rhc_back
  import rhc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire rhc_job_t job,
  input  wire logic     job_valid,
  output logic          job_take,
  output rhc_hsv_t      hsv,
  output logic          empty,
  input  wire logic     pop
);

  function automatic rhc_lane_t div_step(input rhc_lane_t l);
    logic [DEN_W:0] t;
    rhc_lane_t      o;
    t = {l.p, l.w[QUO_W-1]};
    o = l;
    if (t >= {1'b0, l.d}) begin
      o.p = DEN_W'(t - {1'b0, l.d});
      o.w = {l.w[QUO_W-2:0], 1'b1};
    end else begin
      o.p = t[DEN_W-1:0];
      o.w = {l.w[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  rhc_div_t         st      [QUO_W];
  rhc_div_t         st_next [QUO_W];
  logic [QUO_W-1:0] st_valid;
  rhc_div_t         init;
  logic             advance;
  logic             out_valid;
  rhc_hsv_t         res_next;
  logic [QUO_W-1:0] hue_q;

  assign advance  = !out_valid || pop;
  assign job_take = advance;
  assign empty    = !out_valid;

  always_comb begin
    init.hue.p = job.hue_x[NUM_W-1:QUO_W];
    init.hue.w = job.hue_x[QUO_W-1:0];
    init.hue.d = job.hue_d;
    init.sat.p = job.sat_x[NUM_W-1:QUO_W];
    init.sat.w = job.sat_x[QUO_W-1:0];
    init.sat.d = job.sat_d;
    init.gray  = job.gray;
    init.val   = job.val;
  end

  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      st_next[i] = (i == 0) ? init : st[(i == 0) ? 0 : i - 1];
      st_next[i].hue = div_step(st_next[i].hue);
      st_next[i].sat = div_step(st_next[i].sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      st_valid  <= {st_valid[QUO_W-2:0], job_valid};
      out_valid <= st_valid[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < QUO_W; i++) begin
        st[i] <= st_next[i];
      end
    end
  end

  // gray pixels give zero hue and saturation; hue is clamped below a full turn
  always_comb begin
    hue_q = (st[QUO_W-1].hue.w > HUE_TOP) ? HUE_TOP : st[QUO_W-1].hue.w;
    res_next.hue        = st[QUO_W-1].gray ? '0 : hue_q[HUE_W-1:0];
    res_next.saturation = st[QUO_W-1].gray ? '0 : st[QUO_W-1].sat.w[SAT_W-1:0];
    res_next.brightness = st[QUO_W-1].val;
  end

  always_ff @(posedge clk) begin
    if (advance) hsv <= res_next;
  end

  `RHC_ASSERT_IMPL(back_sat_range, out_valid, hsv.saturation <= SAT_ONE, "saturation above one")
  `RHC_ASSERT_NEXT(back_stall_keeps, out_valid && !pop, out_valid && $stable(st_valid), "pipeline moved while output stalled")

endmodule

`default_nettype wire

/* rtl/core/rgb_to_hsv_converter.sv */
// top level of the rgb to hsv converter: front end, job queue, divider back end
// depends on rhc_pkg, rhc_front, rhc_queue, rhc_back
`default_nettype none

//  channel   ports                    payload       accepted when
//  pixels    push, full, pixel        rhc_pixel_t   push && !full
//  results   empty, pop, hsv          rhc_hsv_t     pop && !empty
//
//  one pixel per clock sustained while results are popped; path: front register,
//  queue, 16-stage restoring divider (one quotient bit a stage), result register
//  reset (rst, synchronous) empties the front register, queue and pipeline valids
//  a stalled result output freezes the divider pipeline; the 4-entry queue and
//  front register keep taking pixels until they fill, then full rises

module rgb_to_hsv_converter
  import rhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rhc_pixel_t pixel,
  input  wire logic       push,
  output logic            full,
  output rhc_hsv_t        hsv,
  output logic            empty,
  input  wire logic       pop
);

  // front to queue
  rhc_job_t front_job;
  logic     front_valid;
  logic     queue_full;

  // queue to back end
  rhc_job_t queue_job;
  logic     queue_empty;
  logic     back_take;

  // classify: max, min, sector, divider operands, brightness
  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .push      (push),
    .full      (full),
    .job       (front_job),
    .job_valid (front_valid),
    .job_full  (queue_full)
  );

  // decouples the front end from stalls at the result side
  rhc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (front_job),
    .wr_valid (front_valid),
    .full     (queue_full),
    .rd_data  (queue_job),
    .empty    (queue_empty),
    .rd_take  (back_take)
  );

  // hue and saturation dividers in lockstep, result register at the end
  rhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (queue_job),
    .job_valid (!queue_empty),
    .job_take  (back_take),
    .hsv       (hsv),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire
